// ----- sv/lsw_pkg.sv -----
`timescale 1ns / 1ps

package lsw_pkg;

   // operation codes
   localparam logic OP_TICK       = 1'b0;
   localparam logic OP_HOST_FRAME = 1'b1;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOST_TIMEOUT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AI_TIMEOUT     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_TICK_LIM = 2'd2;

   // register reset values
   localparam logic [31:0] HOST_TIMEOUT_RESET   = 32'd500;
   localparam logic [31:0] AI_TIMEOUT_RESET     = 32'd250;
   localparam logic [31:0] RESET_TICK_LIM_RESET = 32'd1500;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] host_timeout_ms;
      logic [31:0] ai_timeout_ms;
      logic [31:0] reset_tick_limit;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] now_ms;
      logic [7:0]  sequence_counter;
      logic        debug_mode;
   } item_type;

   typedef struct packed {
      logic [7:0]  last_sequence;
      logic [31:0] ai_stamp;
      logic [31:0] host_stamp;
      logic        host_up;
      logic        ai_up;
      logic        ai_seen;
      logic [31:0] frame_total;
      logic [31:0] lost_ticks;
   } state_type;

   typedef struct packed {
      logic        host_connected;
      logic        ai_connected;
      logic        ai_ever_connected;
      logic        rx_led_on;
      logic        clear_command;
      logic        stop_request;
      logic        system_reset;
      logic        host_updated;
      logic [31:0] ai_frame_count;
   } result_type;

endpackage

// ----- sv/link_supervisor_watchdog_core.sv -----
`timescale 1ns / 1ps
// path: a request passes the input register, then one pass of compare/increment
//   logic into the result register; it waits in the input register while rsp_stall holds
// throughput: one item per cycle while the result register is not stalled
// reset: synchronous active high; clears link state, counters and both valid flags
//   and loads the configuration registers with their default values

module link_supervisor_watchdog_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [31:0]                          req_now_ms,
   input  logic [7:0]                           req_sequence_counter,
   input  logic                                 req_debug_mode,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_host_connected,
   output logic                                 rsp_ai_connected,
   output logic                                 rsp_ai_ever_connected,
   output logic                                 rsp_rx_led_on,
   output logic                                 rsp_clear_command,
   output logic                                 rsp_stop_request,
   output logic                                 rsp_system_reset,
   output logic                                 rsp_host_updated,
   output logic [31:0]                          rsp_ai_frame_count,
   // configuration port
   input  logic                                 csr_write_enable,
   input  logic [lsw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_write_data
);
   import lsw_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       step_load;
   logic       req_transfer;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_timeout_ms  <= HOST_TIMEOUT_RESET;
         cfg_ff.ai_timeout_ms    <= AI_TIMEOUT_RESET;
         cfg_ff.reset_tick_limit <= RESET_TICK_LIM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HOST_TIMEOUT:   cfg_ff.host_timeout_ms  <= csr_write_data;
            CSR_AI_TIMEOUT:     cfg_ff.ai_timeout_ms    <= csr_write_data;
            CSR_RESET_TICK_LIM: cfg_ff.reset_tick_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   // handshake: the result register moves when empty or taken
   assign step_load    = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = item_valid_ff && !step_load;
   assign req_transfer = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         item_ff.operation        <= req_operation;
         item_ff.now_ms           <= req_now_ms;
         item_ff.sequence_counter <= req_sequence_counter;
         item_ff.debug_mode       <= req_debug_mode;
      end
   end

   // supervision step
   lsw_step u_step (
      .state      (state_ff),
      .item       (item_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_load) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_host_connected    = result_ff.host_connected;
   assign rsp_ai_connected      = result_ff.ai_connected;
   assign rsp_ai_ever_connected = result_ff.ai_ever_connected;
   assign rsp_rx_led_on         = result_ff.rx_led_on;
   assign rsp_clear_command     = result_ff.clear_command;
   assign rsp_stop_request      = result_ff.stop_request;
   assign rsp_system_reset      = result_ff.system_reset;
   assign rsp_host_updated      = result_ff.host_updated;
   assign rsp_ai_frame_count    = result_ff.ai_frame_count;

   // checks
   a_host_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.host_updated |->
         !result_ff.clear_command && !result_ff.stop_request && !result_ff.system_reset)
      else $error("host frame result carries tick pulses");

   a_ai_implies_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff.ai_up |-> state_ff.ai_seen)
      else $error("ai link up without ever-connected");

   a_state_only_on_step: assert property (@(posedge clock) disable iff (reset)
      !step_load |=> $stable(state_ff))
      else $error("link state changed without a step");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      step_load |=> result_ff.ai_frame_count == state_ff.frame_total
                    && result_ff.ai_connected == state_ff.ai_up)
      else $error("result out of step with link state");

   a_stale_ai_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.clear_command |-> !result_ff.ai_connected)
      else $error("clear command while ai link up");

endmodule

// ----- sv/lsw_step.sv -----
`timescale 1ns / 1ps

module lsw_step (
   input  lsw_pkg::state_type  state,
   input  lsw_pkg::item_type   item,
   input  lsw_pkg::cfg_type    cfg,
   output lsw_pkg::state_type  state_next,
   output lsw_pkg::result_type result
);
   import lsw_pkg::*;

   logic        host_fresh;
   logic        seq_changed;
   logic [31:0] ai_stamp_new;
   logic        ai_fresh;
   logic        ai_seen_new;
   logic        lost_run;
   logic [31:0] lost_inc;
   logic        is_tick;

   assign is_tick = (item.operation == OP_TICK);

   // freshness checks on wrapping time differences
   assign host_fresh   = (item.now_ms - state.host_stamp) < cfg.host_timeout_ms;
   assign seq_changed  = item.sequence_counter != state.last_sequence;
   assign ai_stamp_new = seq_changed ? item.now_ms : state.ai_stamp;
   assign ai_fresh     = (item.now_ms - ai_stamp_new) < cfg.ai_timeout_ms;
   assign ai_seen_new  = state.ai_seen | ai_fresh;

   // lost-host counter, saturating
   assign lost_run = !item.debug_mode && !host_fresh && ai_seen_new;
   assign lost_inc = (state.lost_ticks == COUNT_MAX) ? state.lost_ticks
                                                     : state.lost_ticks + 32'd1;

   // next state
   always_comb begin
      state_next = state;
      if (is_tick) begin
         state_next.host_up = host_fresh;
         // the ai check always decides ai_up, even after a host drop
         state_next.ai_up   = ai_fresh;
         state_next.ai_seen = ai_seen_new;
         if (seq_changed) begin
            state_next.last_sequence = item.sequence_counter;
            state_next.frame_total   = state.frame_total + 32'd1;
            state_next.ai_stamp      = item.now_ms;
         end
         state_next.lost_ticks = lost_run ? lost_inc : 32'd0;
      end else begin
         state_next.host_stamp = item.now_ms;
      end
   end

   // result item
   always_comb begin
      result.host_connected    = state_next.host_up;
      result.ai_connected      = state_next.ai_up;
      result.ai_ever_connected = state_next.ai_seen;
      result.rx_led_on         = state_next.ai_up;
      result.clear_command     = is_tick && !ai_fresh;
      result.stop_request      = is_tick && !ai_fresh;
      result.system_reset      = is_tick && lost_run && (lost_inc > cfg.reset_tick_limit);
      result.host_updated      = !is_tick;
      result.ai_frame_count    = state_next.frame_total;
   end

endmodule
